/* rtl/fm_seek_noise_floor_scan_defines.svh */
// assertion helpers for the seek scan block
`ifndef FM_SEEK_NOISE_FLOOR_SCAN_DEFINES_SVH
`define FM_SEEK_NOISE_FLOOR_SCAN_DEFINES_SVH

// same-cycle implication, checked out of reset only
`define FMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset only
`define FMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fmseek_pkg.sv */
package fmseek_pkg;

    localparam int FREQ_W   = 32;
    localparam int POWER_W  = 32;
    localparam int FACTOR_W = 16;
    localparam int PROD_W   = POWER_W + FACTOR_W;
    localparam int CFG_IDX_W = 3;

    // item function codes
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_MEAS   = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS    = 3'd4;

    // register reset values
    localparam logic [FREQ_W-1:0]   RST_LOWER  = 32'd87500000;
    localparam logic [FREQ_W-1:0]   RST_UPPER  = 32'd108000000;
    localparam logic [FREQ_W-1:0]   RST_STEP   = 32'd100000;
    localparam logic [FACTOR_W-1:0] RST_FACTOR = 16'd1536;
    localparam logic [POWER_W-1:0]  RST_ABS    = 32'd0;

    typedef struct packed {
        logic [1:0]         func;
        logic               direction_up;
        logic [FREQ_W-1:0]  start_freq;
        logic [POWER_W-1:0] power;
    } t_in_item;

    typedef struct packed {
        logic [FREQ_W-1:0] tune_freq;
        logic              seeking;
        logic              done_res;
        logic              found;
        logic [FREQ_W-1:0] found_freq;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_CMP
    } t_state;

endpackage

/* rtl/fm_seek_noise_floor_scan.sv */
// FM seek controller with a running-minimum noise floor. A start item begins a
// scan from start_freq upward or downward, stepping by step_freq and wrapping
// inside the lower and upper band edges; every item returns exactly one result
// carrying the frequency the tuner should take next. Each measurement item
// lowers the noise floor if its power is smaller, and from the second
// measurement on a station is found when power exceeds abs_threshold, or the
// floor times floor_factor (UQ8.8) when abs_threshold is zero. The scan ends on
// a station, after (upper-lower)/step+1 measurements, or on a cancel item, and
// retunes to the station or back to the start frequency. A start item waits for
// the radix-2 divider that counts the channels in the band (one quotient bit per
// cycle); a measurement passes through the registered floor-times-factor
// product. A start with a zero step or an upper edge not above the lower edge
// ends the scan at once. The result sits in an output register, so the
// following item can be accepted in the cycle the result is taken. The config
// port is always ready; registers must be written only while no item is in
// progress, which the block itself does not enforce.
`include "fm_seek_noise_floor_scan_defines.svh"

module fm_seek_noise_floor_scan
    import fmseek_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // config registers
    logic [FREQ_W-1:0]   r_lower;
    logic [FREQ_W-1:0]   r_upper;
    logic [FREQ_W-1:0]   r_step;
    logic [FACTOR_W-1:0] r_factor;
    logic [POWER_W-1:0]  r_abs;

    // sequencer and captured item
    t_state              r_state;
    t_state              n_state;
    t_in_item            r_item;

    // scan state
    logic [FREQ_W-1:0]   r_cur,    n_cur;
    logic [FREQ_W-1:0]   r_origin, n_origin;
    logic [POWER_W-1:0]  r_floor,  n_floor;
    logic [31:0]         r_idx,    n_idx;
    logic [31:0]         r_total,  n_total;
    logic                r_active, n_active;
    logic                r_up,     n_up;
    logic [PROD_W-1:0]   r_prod,   n_prod;

    // output register
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           n_out;
    logic                w_out_load;

    logic                w_in_acc;
    logic                w_band_ok;
    logic                w_div_start;
    logic                w_div_done;
    logic [FREQ_W-1:0]   w_quot;
    logic [32:0]         w_total_sum;
    logic [FREQ_W-1:0]   w_nf_base;
    logic                w_nf_up;
    logic [FREQ_W-1:0]   w_nf;
    logic [POWER_W-1:0]  w_min;
    logic                w_hit;
    logic [31:0]         w_idx_inc;

    // one frequency step with wrap, sums kept one bit wider so edge tests are exact
    function automatic logic [FREQ_W-1:0] f_next(
        input logic [FREQ_W-1:0] f,
        input logic              up,
        input logic [FREQ_W-1:0] lo,
        input logic [FREQ_W-1:0] hi,
        input logic [FREQ_W-1:0] st
    );
        logic [FREQ_W:0] sum_up;
        logic [FREQ_W:0] lo_st;
        begin
            sum_up = {1'b0, f} + {1'b0, st};
            lo_st  = {1'b0, lo} + {1'b0, st};
            if (up) begin
                f_next = (sum_up > {1'b0, hi}) ? lo : sum_up[FREQ_W-1:0];
            end else begin
                f_next = ({1'b0, f} < lo_st) ? hi : (f - st);
            end
        end
    endfunction

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower  <= RST_LOWER;
            r_upper  <= RST_UPPER;
            r_step   <= RST_STEP;
            r_factor <= RST_FACTOR;
            r_abs    <= RST_ABS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOWER:  r_lower  <= i_cfg_data;
                CFG_UPPER:  r_upper  <= i_cfg_data;
                CFG_STEP:   r_step   <= i_cfg_data;
                CFG_FACTOR: r_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_ABS:    r_abs    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // channel count divider, run once per valid start
    fmseek_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_upper - r_lower),
        .i_divisor  (r_step),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_band_ok   = (r_step != '0) && (r_upper > r_lower);
    assign w_total_sum = {1'b0, w_quot} + 33'd1;

    // shared stepper: from the start frequency when a scan opens, else from current
    assign w_nf_base = (r_state == S_DIV) ? r_item.start_freq   : r_cur;
    assign w_nf_up   = (r_state == S_DIV) ? r_item.direction_up : r_up;
    assign w_nf      = f_next(w_nf_base, w_nf_up, r_lower, r_upper, r_step);

    // floor update and threshold test
    assign w_min     = (r_item.power < r_floor) ? r_item.power : r_floor;
    assign w_hit     = (r_abs != '0) ? (r_item.power > r_abs)
                                     : ({8'd0, r_item.power, 8'd0} > r_prod);
    assign w_idx_inc = r_idx + 32'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_DECODE;
            end
            S_DECODE: begin
                if ((r_item.func == FUNC_START) && w_band_ok) begin
                    n_state = S_DIV;
                end else if ((r_item.func == FUNC_MEAS) && r_active) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (w_div_done) n_state = S_IDLE;
            end
            S_CMP:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_cur       = r_cur;
        n_origin    = r_origin;
        n_floor     = r_floor;
        n_idx       = r_idx;
        n_total     = r_total;
        n_active    = r_active;
        n_up        = r_up;
        n_prod      = r_prod;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        n_out       = '{tune_freq: r_cur, seeking: r_active, done_res: 1'b0,
                        found: 1'b0, found_freq: '0};
        case (r_state)
            S_DECODE: begin
                case (r_item.func)
                    FUNC_START: begin
                        if (w_band_ok) begin
                            w_div_start = 1'b1;
                        end else begin
                            // bad band or zero step ends at once
                            n_active   = 1'b0;
                            n_cur      = r_item.start_freq;
                            w_out_load = 1'b1;
                            n_out      = '{tune_freq: r_item.start_freq, seeking: 1'b0,
                                           done_res: 1'b1, found: 1'b0, found_freq: '0};
                        end
                    end
                    FUNC_MEAS: begin
                        if (r_active) begin
                            n_floor = w_min;
                            n_prod  = {{FACTOR_W{1'b0}}, w_min} *
                                      {{POWER_W{1'b0}}, r_factor};
                        end else begin
                            w_out_load = 1'b1;
                        end
                    end
                    FUNC_CANCEL: begin
                        w_out_load = 1'b1;
                        if (r_active) begin
                            n_active = 1'b0;
                            n_cur    = r_origin;
                            n_out    = '{tune_freq: r_origin, seeking: 1'b0,
                                         done_res: 1'b1, found: 1'b0, found_freq: '0};
                        end
                    end
                    default: w_out_load = 1'b1;
                endcase
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_total    = w_total_sum[32] ? 32'hFFFF_FFFF : w_total_sum[31:0];
                    n_origin   = r_item.start_freq;
                    n_up       = r_item.direction_up;
                    n_floor    = '1;
                    n_idx      = '0;
                    n_active   = 1'b1;
                    n_cur      = w_nf;
                    w_out_load = 1'b1;
                    n_out      = '{tune_freq: w_nf, seeking: 1'b1, done_res: 1'b0,
                                   found: 1'b0, found_freq: '0};
                end
            end
            S_CMP: begin
                w_out_load = 1'b1;
                if ((r_idx != '0) && w_hit) begin
                    // station at the current frequency
                    n_active = 1'b0;
                    n_out    = '{tune_freq: r_cur, seeking: 1'b0, done_res: 1'b1,
                                 found: 1'b1, found_freq: r_cur};
                end else begin
                    n_idx = w_idx_inc;
                    if (w_idx_inc >= r_total) begin
                        // band exhausted, back to the start frequency
                        n_active = 1'b0;
                        n_cur    = r_origin;
                        n_out    = '{tune_freq: r_origin, seeking: 1'b0, done_res: 1'b1,
                                     found: 1'b0, found_freq: '0};
                    end else begin
                        n_cur = w_nf;
                        n_out = '{tune_freq: w_nf, seeking: 1'b1, done_res: 1'b0,
                                  found: 1'b0, found_freq: '0};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_origin    <= '0;
            r_floor     <= '1;
            r_idx       <= '0;
            r_total     <= '0;
            r_active    <= 1'b0;
            r_up        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_origin <= n_origin;
            r_floor  <= n_floor;
            r_idx    <= n_idx;
            r_total  <= n_total;
            r_active <= n_active;
            r_up     <= n_up;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_item <= i_in;
        if (w_out_load) r_out <= n_out;
        r_prod <= n_prod;
    end

    // an accepted item is always decoded in the next cycle
    `FMS_ASSERT_NEXT(a_acc_decode, w_in_acc, r_state == S_DECODE, "item not decoded after accept")
    // the divider only reports while a start waits for it
    `FMS_ASSERT_NOW(a_div_owner, w_div_done, r_state == S_DIV, "divider done outside start")
    // a new result never lands on one still waiting
    `FMS_ASSERT_NOW(a_out_free, w_out_load, !r_out_valid, "result register overwritten")
    // an open scan always has at least one channel to visit
    `FMS_ASSERT_NOW(a_total_nz, r_active, r_total != '0, "scan open with no channels")

endmodule

/* rtl/fmseek_div.sv */
module fmseek_div
    import fmseek_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FREQ_W-1:0] i_dividend,
    input  logic [FREQ_W-1:0] i_divisor,
    output logic              o_done,
    output logic [FREQ_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(FREQ_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FREQ_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [FREQ_W-1:0] r_rem;
    logic [FREQ_W-1:0] r_quot;
    logic [FREQ_W-1:0] r_div;

    logic [FREQ_W:0]   w_trial;
    logic [FREQ_W:0]   w_diff;
    logic              w_ge;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quot[FREQ_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[FREQ_W-1:0] : w_trial[FREQ_W-1:0];
            r_quot <= {r_quot[FREQ_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
